FILE: rtl/fti_pkg.sv
package fti_pkg;

    localparam int CNT_W      = 8;
    localparam int IDX_W      = 4;
    localparam int GRADE_W    = 3;
    localparam int GRADE_PTS  = 11;
    localparam int NUM_W      = 9;
    localparam int DEN_W      = 6;
    localparam int FRAC_BITS  = 8;
    localparam int QUO_W      = 12;
    localparam int DIV_STAGES = 4;
    localparam int DIV_STEP   = QUO_W / DIV_STAGES;
    localparam int DVD_W      = NUM_W + FRAC_BITS;
    localparam int IN_W       = 3 * CNT_W;
    localparam int OUT_W      = ((QUO_W + 7) / 8) * 8;

    localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(GRADE_PTS - 1);

    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic [GRADE_W-1:0] grade_t;
    typedef logic [NUM_W-1:0]   num_t;
    typedef logic [DEN_W-1:0]   den_t;

    // grades in sixths for counts 0..10
    localparam grade_t REQ_LOW  [GRADE_PTS] =
        '{3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd3, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0};
    localparam grade_t REQ_HIGH [GRADE_PTS] =
        '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd3, 3'd6, 3'd3, 3'd0, 3'd0};
    localparam grade_t REQ_VHI  [GRADE_PTS] =
        '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd3, 3'd6};
    localparam grade_t REP_LOW  [GRADE_PTS] =
        '{3'd6, 3'd6, 3'd3, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0};
    localparam grade_t REP_HIGH [GRADE_PTS] =
        '{3'd0, 3'd0, 3'd3, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6};
    localparam grade_t ACT_LOW  [GRADE_PTS] =
        '{3'd6, 3'd6, 3'd3, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0};
    localparam grade_t ACT_MED  [GRADE_PTS] =
        '{3'd0, 3'd0, 3'd2, 3'd4, 3'd6, 3'd3, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0};
    localparam grade_t ACT_HIGH [GRADE_PTS] =
        '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd3, 3'd6, 3'd6, 3'd6, 3'd6};

    typedef struct packed {
        grade_t rl;
        grade_t rh;
        grade_t rv;
        grade_t pl;
        grade_t ph;
        grade_t al;
        grade_t am;
        grade_t ah;
    } grades_t;

    typedef struct packed {
        grade_t vl;
        grade_t l;
        grade_t m;
        grade_t h;
        grade_t vh;
    } classes_t;

    typedef struct packed {
        den_t             rem;
        den_t             den;
        logic [QUO_W-1:0] low;
        logic [QUO_W-1:0] quo;
        logic             zero;
    } div_t;

    function automatic idx_t clamp_count(input logic [CNT_W-1:0] c);
        return (c > CNT_W'(IDX_MAX)) ? IDX_MAX : c[IDX_W-1:0];
    endfunction

    function automatic grade_t min3(input grade_t a, input grade_t b, input grade_t c);
        grade_t t;
        t = (a < b) ? a : b;
        return (t < c) ? t : c;
    endfunction

    function automatic grade_t max2(input grade_t a, input grade_t b);
        return (a > b) ? a : b;
    endfunction

endpackage

FILE: rtl/fti_div.sv
module fti_div (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  fti_pkg::num_t         in_num,
    input  fti_pkg::den_t         in_den,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [fti_pkg::QUO_W-1:0] out_quo
);

    localparam int NS = fti_pkg::DIV_STAGES;

    fti_pkg::div_t pipe_reg [NS];
    fti_pkg::div_t stage_next [NS];
    fti_pkg::div_t src [NS];
    logic          vld_reg [NS];
    logic          src_vld [NS];
    logic          rdy [NS+1];

    fti_pkg::div_t                  entry;
    logic [fti_pkg::DVD_W-1:0]      dividend;

    // dividend is num scaled by 2^FRAC_BITS; the top bits start the remainder
    always_comb begin
        dividend   = {in_num, {fti_pkg::FRAC_BITS{1'b0}}};
        entry.rem  = fti_pkg::DEN_W'(dividend[fti_pkg::DVD_W-1:fti_pkg::QUO_W]);
        entry.den  = in_den;
        entry.low  = dividend[fti_pkg::QUO_W-1:0];
        entry.quo  = '0;
        entry.zero = (in_den == '0);
    end

    assign rdy[NS]  = out_ready;
    assign in_ready = rdy[0];

    for (genvar k = 0; k < NS; k++) begin : g_stage
        if (k == 0) begin : g_first
            assign src[k]     = entry;
            assign src_vld[k] = in_valid;
        end else begin : g_rest
            assign src[k]     = pipe_reg[k-1];
            assign src_vld[k] = vld_reg[k-1];
        end

        assign rdy[k] = !vld_reg[k] || rdy[k+1];

        // one restoring step per quotient bit
        always_comb begin
            fti_pkg::div_t           st;
            logic [fti_pkg::DEN_W:0] r_ext;
            st = src[k];
            for (int j = 0; j < fti_pkg::DIV_STEP; j++) begin
                r_ext  = {st.rem, st.low[fti_pkg::QUO_W-1]};
                st.low = {st.low[fti_pkg::QUO_W-2:0], 1'b0};
                if (r_ext >= {1'b0, st.den}) begin
                    st.rem = fti_pkg::DEN_W'(r_ext - {1'b0, st.den});
                    st.quo = {st.quo[fti_pkg::QUO_W-2:0], 1'b1};
                end else begin
                    st.rem = r_ext[fti_pkg::DEN_W-1:0];
                    st.quo = {st.quo[fti_pkg::QUO_W-2:0], 1'b0};
                end
            end
            stage_next[k] = st;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (rdy[k]) begin
                vld_reg[k] <= src_vld[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (rdy[k] && src_vld[k]) begin
                pipe_reg[k] <= stage_next[k];
            end
        end
    end

    assign out_valid = vld_reg[NS-1];
    // a zero divisor answers zero
    assign out_quo   = pipe_reg[NS-1].zero ? '0 : pipe_reg[NS-1].quo;

endmodule

FILE: rtl/fuzzy_trust_inference.sv
// Channel  | Ports                       | Contents (lowest bit up)
// ---------+-----------------------------+---------------------------------------------
// request  | s_tvalid s_tready s_tdata   | request_count[7:0] reply_count[15:8]
//          |                             | activity_count[23:16]
// result   | m_tvalid m_tready m_tdata   | trust_value[11:0], zeros [15:12]
//
// Seven register stages: grades, rule strengths, weighted sums, then four
// divider stages of three quotient bits each. One request per cycle while
// m_tready does not stall; each result passes through all seven in order.
// aresetn clears only the valid bits; payload registers are not reset.
// Each stage advances when it is empty or the next one takes its request,
// so a stall at m_tready fills bubbles before it holds s_tready low.
module fuzzy_trust_inference (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // request_count, reply_count, activity_count
    input  logic [fti_pkg::IN_W-1:0]      s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // trust_value, zero fill
    output logic [fti_pkg::OUT_W-1:0]     m_tdata
);

    localparam int CW = fti_pkg::CNT_W;

    fti_pkg::grades_t  grades_reg, grades_next;
    fti_pkg::classes_t classes_reg, classes_next;
    fti_pkg::num_t     num_reg, num_next;
    fti_pkg::den_t     den_reg, den_next;
    logic              v1_reg, v2_reg, v3_reg;
    logic              rdy1, rdy2, rdy3;
    logic              div_ready;
    logic              div_valid;
    logic [fti_pkg::QUO_W-1:0] div_quo;

    fti_pkg::idx_t q_idx, p_idx, a_idx;

    assign rdy3     = !v3_reg || div_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;

    // grading; every membership is flat from ten upward
    always_comb begin
        q_idx = fti_pkg::clamp_count(s_tdata[CW-1:0]);
        p_idx = fti_pkg::clamp_count(s_tdata[2*CW-1:CW]);
        a_idx = fti_pkg::clamp_count(s_tdata[3*CW-1:2*CW]);
        grades_next.rl = fti_pkg::REQ_LOW[q_idx];
        grades_next.rh = fti_pkg::REQ_HIGH[q_idx];
        grades_next.rv = fti_pkg::REQ_VHI[q_idx];
        grades_next.pl = fti_pkg::REP_LOW[p_idx];
        grades_next.ph = fti_pkg::REP_HIGH[p_idx];
        grades_next.al = fti_pkg::ACT_LOW[a_idx];
        grades_next.am = fti_pkg::ACT_MED[a_idx];
        grades_next.ah = fti_pkg::ACT_HIGH[a_idx];
    end

    // rule strengths, joined per trust class
    always_comb begin
        fti_pkg::grades_t g;
        g = grades_reg;
        classes_next.vh = fti_pkg::min3(g.rl, g.pl, g.al);
        classes_next.h  = fti_pkg::min3(g.rh, g.pl, g.am);
        classes_next.m  = fti_pkg::max2(
            fti_pkg::max2(
                fti_pkg::max2(fti_pkg::min3(g.rl, g.ph, g.al),
                              fti_pkg::min3(g.rh, g.pl, g.al)),
                fti_pkg::max2(fti_pkg::min3(g.rh, g.ph, g.al),
                              fti_pkg::min3(g.rv, g.pl, g.al))),
            fti_pkg::max2(
                fti_pkg::max2(fti_pkg::min3(g.rv, g.ph, g.al),
                              fti_pkg::min3(g.rv, g.ph, g.am)),
                fti_pkg::min3(g.rl, g.pl, g.am)));
        classes_next.l  = fti_pkg::max2(
            fti_pkg::max2(
                fti_pkg::max2(fti_pkg::min3(g.rl, g.ph, g.am),
                              fti_pkg::min3(g.rh, g.pl, g.ah)),
                fti_pkg::max2(fti_pkg::min3(g.rh, g.ph, g.am),
                              fti_pkg::min3(g.rv, g.pl, g.am))),
            fti_pkg::min3(g.rv, g.pl, g.ah));
        classes_next.vl = fti_pkg::max2(
            fti_pkg::max2(fti_pkg::min3(g.rl, g.pl, g.ah),
                          fti_pkg::min3(g.rl, g.ph, g.ah)),
            fti_pkg::max2(fti_pkg::min3(g.rh, g.ph, g.ah),
                          fti_pkg::min3(g.rv, g.ph, g.ah)));
    end

    // weighted sums for the centroid
    always_comb begin
        fti_pkg::classes_t c;
        c = classes_reg;
        num_next = fti_pkg::NUM_W'(6)  * fti_pkg::NUM_W'(c.vl)
                 + fti_pkg::NUM_W'(4)  * fti_pkg::NUM_W'(c.l)
                 + fti_pkg::NUM_W'(5)  * fti_pkg::NUM_W'(c.m)
                 + fti_pkg::NUM_W'(6)  * fti_pkg::NUM_W'(c.h)
                 + fti_pkg::NUM_W'(34) * fti_pkg::NUM_W'(c.vh);
        den_next = fti_pkg::DEN_W'(3) * fti_pkg::DEN_W'(c.vl)
                 + fti_pkg::DEN_W'(c.l) + fti_pkg::DEN_W'(c.m) + fti_pkg::DEN_W'(c.h)
                 + fti_pkg::DEN_W'(4) * fti_pkg::DEN_W'(c.vh);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= s_tvalid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && s_tvalid) begin
            grades_reg <= grades_next;
        end
        if (rdy2 && v1_reg) begin
            classes_reg <= classes_next;
        end
        if (rdy3 && v2_reg) begin
            num_reg <= num_next;
            den_reg <= den_next;
        end
    end

    fti_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v3_reg),
        .in_ready  (div_ready),
        .in_num    (num_reg),
        .in_den    (den_reg),
        .out_valid (div_valid),
        .out_ready (m_tready),
        .out_quo   (div_quo)
    );

    assign m_tvalid = div_valid;
    assign m_tdata  = fti_pkg::OUT_W'(div_quo);

endmodule
